// ----- rtl/rmq_pkg.sv -----
package rmq_pkg;

    // Default number of fraction bits of the matrix and quaternion elements
    localparam int FRAC_BITS_DEF = 14;

    // Fixed field widths
    localparam int IN_W   = 16;
    localparam int NUM_W  = 17;   // difference or sum of two elements
    localparam int QB     = 16;   // quotient bits resolved by the divider
    localparam int CASE_W = 2;
    localparam int SIDE_W = CASE_W + 1 + 3 * NUM_W;

    // Branch codes
    localparam logic [CASE_W-1:0] CASE_TRACE = 2'd0;
    localparam logic [CASE_W-1:0] CASE_X     = 2'd1;
    localparam logic [CASE_W-1:0] CASE_Y     = 2'd2;
    localparam logic [CASE_W-1:0] CASE_Z     = 2'd3;

    // Sideband layout: {case, degenerate, n0, n1, n2}
    localparam int SB_N2   = 0;
    localparam int SB_N1   = NUM_W;
    localparam int SB_N0   = 2 * NUM_W;
    localparam int SB_DEG  = 3 * NUM_W;
    localparam int SB_CASE = 3 * NUM_W + 1;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Width of the signed square-root argument
    function automatic int arg_w(input int fb);
        return imax(fb, 17) + 3;
    endfunction

    // Even width of the radicand arg << fb
    function automatic int rad_w(input int fb);
        int w;
        w = arg_w(fb) - 1 + fb;
        return w + (w % 2);
    endfunction

    // Width of the dividend and divisor working registers
    function automatic int div_w(input int fb);
        int rw;
        rw = rad_w(fb) / 2;
        return imax(imax(NUM_W + fb, rw) + 1, rw + 1 + QB);
    endfunction

endpackage

// ----- rtl/rmq_front.sv -----
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [9*rmq_pkg::IN_W-1:0]   in_data,
    output logic                         vld,
    output logic [rmq_pkg::rad_w(FRAC_BITS)-1:0] rad,
    output logic [rmq_pkg::SIDE_W-1:0]   side
);
    localparam int AW = rmq_pkg::arg_w(FRAC_BITS);
    localparam int SW = rmq_pkg::rad_w(FRAC_BITS);
    localparam int NW = rmq_pkg::NUM_W;
    localparam int IW = rmq_pkg::IN_W;

    logic signed [IW-1:0] a00, a10, a20, a01, a11, a21, a02, a12, a22;
    logic signed [AW-1:0] e00, e11, e22, one, trace, arg;
    logic signed [NW-1:0] n0, n1, n2;
    logic [rmq_pkg::CASE_W-1:0] sel;
    logic degen;
    logic [SW-1:0] rad_next;
    logic vld_reg;
    logic [SW-1:0] rad_reg;
    logic [rmq_pkg::SIDE_W-1:0] side_reg;

    assign a00 = in_data[0*IW +: IW];
    assign a10 = in_data[1*IW +: IW];
    assign a20 = in_data[2*IW +: IW];
    assign a01 = in_data[3*IW +: IW];
    assign a11 = in_data[4*IW +: IW];
    assign a21 = in_data[5*IW +: IW];
    assign a02 = in_data[6*IW +: IW];
    assign a12 = in_data[7*IW +: IW];
    assign a22 = in_data[8*IW +: IW];

    assign e00   = AW'(a00);
    assign e11   = AW'(a11);
    assign e22   = AW'(a22);
    assign one   = AW'(1) <<< FRAC_BITS;
    assign trace = e00 + e11 + e22;

    // Branch choice, root argument and numerators
    always_comb
    begin
        priority if (trace > 0)
        begin
            sel = rmq_pkg::CASE_TRACE;
            arg = trace + one;
            n0  = NW'(a21) - NW'(a12);
            n1  = NW'(a02) - NW'(a20);
            n2  = NW'(a10) - NW'(a01);
        end
        else if (a00 > a11 && a00 > a22)
        begin
            sel = rmq_pkg::CASE_X;
            arg = one + e00 - e11 - e22;
            n0  = NW'(a21) - NW'(a12);
            n1  = NW'(a01) + NW'(a10);
            n2  = NW'(a02) + NW'(a20);
        end
        else if (a11 > a22)
        begin
            sel = rmq_pkg::CASE_Y;
            arg = one + e11 - e00 - e22;
            n0  = NW'(a02) - NW'(a20);
            n1  = NW'(a01) + NW'(a10);
            n2  = NW'(a12) + NW'(a21);
        end
        else
        begin
            sel = rmq_pkg::CASE_Z;
            arg = one + e22 - e00 - e11;
            n0  = NW'(a10) - NW'(a01);
            n1  = NW'(a02) + NW'(a20);
            n2  = NW'(a12) + NW'(a21);
        end
    end

    // Degenerate items run the root on a harmless argument
    assign degen    = (arg <= 0);
    assign rad_next = degen ? (SW'(1) << FRAC_BITS)
                            : (SW'(arg[AW-2:0]) << FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            side_reg <= {sel, degen, n0, n1, n2};
        end
    end

    assign vld  = vld_reg;
    assign rad  = rad_reg;
    assign side = side_reg;
endmodule

// ----- rtl/rmq_sqrt.sv -----
module rmq_sqrt #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_vld,
    input  logic [rmq_pkg::rad_w(FRAC_BITS)-1:0]  in_rad,
    input  logic [rmq_pkg::SIDE_W-1:0]            in_side,
    output logic                                  vld,
    output logic [rmq_pkg::rad_w(FRAC_BITS)/2-1:0] root,
    output logic [rmq_pkg::SIDE_W-1:0]            side
);
    localparam int SW = rmq_pkg::rad_w(FRAC_BITS);
    localparam int RW = SW / 2;

    // One result bit per stage
    logic              vld_reg  [0:RW-1];
    logic [SW-1:0]     rad_reg  [0:RW-1];
    logic [RW+1:0]     rem_reg  [0:RW-1];
    logic [RW-1:0]     root_reg [0:RW-1];
    logic [rmq_pkg::SIDE_W-1:0] side_reg [0:RW-1];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic              v_in;
        logic [SW-1:0]     rad_in;
        logic [RW+1:0]     rem_in;
        logic [RW-1:0]     root_in;
        logic [rmq_pkg::SIDE_W-1:0] side_in;
        logic [RW+1:0]     rem_sh, trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign v_in    = in_vld;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = vld_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-1:0], rad_in[SW-1:SW-2]};
        assign trial  = {root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[RW-2:0], take};
                side_reg[k] <= side_in;
            end
        end
    end

    assign vld  = vld_reg[RW-1];
    assign root = root_reg[RW-1];
    assign side = side_reg[RW-1];
endmodule

// ----- rtl/rmq_div.sv -----
module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic [rmq_pkg::rad_w(FRAC_BITS)/2-1:0] in_root,
    input  logic [rmq_pkg::SIDE_W-1:0]             in_side,
    output logic                                   vld,
    output logic [rmq_pkg::rad_w(FRAC_BITS)/2-1:0] root,
    output logic [rmq_pkg::CASE_W-1:0]             sel,
    output logic                                   degen,
    output logic [2:0][rmq_pkg::QB-1:0]            quo,
    output logic [2:0]                             ovf,
    output logic [2:0]                             neg
);
    localparam int RW = rmq_pkg::rad_w(FRAC_BITS) / 2;
    localparam int CW = rmq_pkg::div_w(FRAC_BITS);
    localparam int NW = rmq_pkg::NUM_W;
    localparam int QB = rmq_pkg::QB;
    localparam int NS = QB + 1;

    // Stage 0 prepares the dividends, stages 1..QB resolve one bit each
    logic                         vld_reg  [0:NS-1];
    logic [CW-1:0]                den_reg  [0:NS-1];
    logic [2:0][CW-1:0]           rem_reg  [0:NS-1];
    logic [2:0][QB-1:0]           quo_reg  [0:NS-1];
    logic [2:0]                   ovf_reg  [0:NS-1];
    logic [2:0]                   neg_reg  [0:NS-1];
    logic [RW-1:0]                root_reg [0:NS-1];
    logic [rmq_pkg::CASE_W-1:0]   sel_reg  [0:NS-1];
    logic                         deg_reg  [0:NS-1];

    logic [2:0][NW-1:0] num;
    logic [2:0][CW-1:0] dvd;
    logic [2:0]         sgn, big;
    logic [CW-1:0]      den0;

    assign num[0] = in_side[rmq_pkg::SB_N0 +: NW];
    assign num[1] = in_side[rmq_pkg::SB_N1 +: NW];
    assign num[2] = in_side[rmq_pkg::SB_N2 +: NW];
    assign den0   = CW'(in_root) << 1;

    // Rounded dividend |n| * ONE + root, and a check for quotients past QB bits
    for (genvar l = 0; l < 3; l++)
    begin : g_prep
        logic [NW-1:0] mag;
        assign sgn[l] = num[l][NW-1];
        assign mag    = sgn[l] ? (~num[l] + NW'(1)) : num[l];
        assign dvd[l] = (CW'(mag) << FRAC_BITS) + CW'(in_root);
        assign big[l] = (dvd[l] >= (den0 << QB));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= den0;
            rem_reg[0]  <= dvd;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= big;
            neg_reg[0]  <= sgn;
            root_reg[0] <= in_root;
            sel_reg[0]  <= in_side[rmq_pkg::SB_CASE +: rmq_pkg::CASE_W];
            deg_reg[0]  <= in_side[rmq_pkg::SB_DEG];
        end
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_stage
        logic [CW-1:0]      sh;
        logic [2:0][CW-1:0] rem_n;
        logic [2:0][QB-1:0] quo_n;

        assign sh = den_reg[s-1] << (QB - s);

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic take;
            assign take     = (rem_reg[s-1][l] >= sh);
            assign rem_n[l] = take ? (rem_reg[s-1][l] - sh) : rem_reg[s-1][l];
            assign quo_n[l] = quo_reg[s-1][l] | (QB'(take) << (QB - s));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s]  <= den_reg[s-1];
                rem_reg[s]  <= rem_n;
                quo_reg[s]  <= quo_n;
                ovf_reg[s]  <= ovf_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                root_reg[s] <= root_reg[s-1];
                sel_reg[s]  <= sel_reg[s-1];
                deg_reg[s]  <= deg_reg[s-1];
            end
        end
    end

    assign vld   = vld_reg[NS-1];
    assign root  = root_reg[NS-1];
    assign sel   = sel_reg[NS-1];
    assign degen = deg_reg[NS-1];
    assign quo   = quo_reg[NS-1];
    assign ovf   = ovf_reg[NS-1];
    assign neg   = neg_reg[NS-1];
endmodule

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to quaternion converter (Shepperd's method), fixed point.
// Input stream s_axis: one item is a 3x3 rotation matrix given as its
// forward, right and up column vectors, each element signed Q1.FRAC_BITS.
// Output stream m_axis: one item per input item, the quaternion
// (w, x, y, z) saturated to 16 bits, with the branch taken and a
// degenerate flag on tuser. Degenerate items carry an all-zero quaternion.
// Throughput: one item per cycle, no gaps between items, unless stalled.
// Pipeline: front-end register, square-root stages, divider preparation
// stage, quotient stages and output register. The square root resolves
// one bit per stage of its RW = rad_w(FRAC_BITS)/2 bit root (17 bits at
// FRAC_BITS = 14); the three dividers one quotient bit per stage each.
// Stalls: the whole pipeline holds while m_axis_tready is low and a result
// waits; s_axis_tready then drops too. Nothing is dropped or repeated.
// Reset: clears all valid bits; the pipeline is empty afterwards.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, up_x, up_y, up_z
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [63:0]  m_axis_tdata,
    // case_taken[1:0], degenerate
    output logic [2:0]   m_axis_tuser
);
    localparam int SW = rmq_pkg::rad_w(FRAC_BITS);
    localparam int RW = SW / 2;
    localparam int QB = rmq_pkg::QB;

    logic en;
    logic f_vld, s_vld, d_vld;
    logic [SW-1:0] f_rad;
    logic [rmq_pkg::SIDE_W-1:0] f_side, s_side;
    logic [RW-1:0] s_root, d_root;
    logic [rmq_pkg::CASE_W-1:0] d_sel;
    logic d_degen;
    logic [2:0][QB-1:0] d_quo;
    logic [2:0] d_ovf, d_neg;

    logic [2:0][15:0] o;
    logic [15:0] diag;
    logic [3:0][15:0] q;
    logic out_vld_reg;
    logic [63:0] out_data_reg;
    logic [2:0]  out_user_reg;

    // Whole pipeline advances unless a result waits at the output
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(s_axis_tvalid), .in_data(s_axis_tdata),
        .vld(f_vld), .rad(f_rad), .side(f_side)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(f_vld), .in_rad(f_rad), .in_side(f_side),
        .vld(s_vld), .root(s_root), .side(s_side)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(s_vld), .in_root(s_root), .in_side(s_side),
        .vld(d_vld), .root(d_root), .sel(d_sel), .degen(d_degen),
        .quo(d_quo), .ovf(d_ovf), .neg(d_neg)
    );

    // Sign and saturate the three quotients
    for (genvar l = 0; l < 3; l++)
    begin : g_sat
        always_comb
        begin
            if (d_neg[l])
                o[l] = (d_ovf[l] || d_quo[l] > QB'(32768)) ? 16'h8000
                                                            : 16'(~d_quo[l] + QB'(1));
            else
                o[l] = (d_ovf[l] || d_quo[l] > QB'(32767)) ? 16'h7fff : 16'(d_quo[l]);
        end
    end

    // Diagonal component floor(root / 2), positive
    assign diag = ((d_root >> 1) > RW'(32767)) ? 16'h7fff : 16'(d_root >> 1);

    // Place the components by branch
    always_comb
    begin
        unique case (d_sel)
            rmq_pkg::CASE_TRACE: q = {o[2], o[1], o[0], diag};
            rmq_pkg::CASE_X:     q = {o[2], o[1], diag, o[0]};
            rmq_pkg::CASE_Y:     q = {o[2], diag, o[1], o[0]};
            rmq_pkg::CASE_Z:     q = {diag, o[2], o[1], o[0]};
            default:             q = '0;
        endcase
        if (d_degen)
            q = '0;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= q;
            out_user_reg <= {d_degen, d_sel};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_user_reg[2], out_user_reg[1:0]};
endmodule

// ----- sim/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB        = rmq_pkg::FRAC_BITS_DEF;
    localparam int ONE       = 1 << FB;
    localparam int LATENCY   = 36;
    localparam int N_RANDOM  = 800;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [15:0]                qz;
        logic [15:0]                qy;
        logic [15:0]                qx;
        logic [15:0]                qw;
        logic [rmq_pkg::CASE_W-1:0] branch;
        logic                       degen;
    } quat_t;

    // directed matrix with optional typed-in expectation
    typedef struct {
        logic signed [15:0] m [9];
        bit                 typed;
        quat_t              res;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    quat_t  quat_queue[$];
    int     errors;
    int     cycles;
    bit     sink_hold;
    bit     sink_busy_free;

    rotation_matrix_to_quaternion i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // integer square root, floor
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // num * ONE / (2 * root), rounded half away from zero, clipped to int32
    function automatic longint div_round(input longint num, input longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        longint          r;
        mag = (num < 0) ? -num : num;
        q   = ((mag << FB) + root) / (2 * root);
        r   = (q > 64'd2147483647) ? 2147483647 : q;
        return (num < 0) ? -r : r;
    endfunction

    function automatic logic [15:0] clip16(input longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // quaternion predicted from the nine matrix elements
    function automatic quat_t predict_quat(input logic signed [15:0] m [9]);
        longint a00, a10, a20, a01, a11, a21, a02, a12, a22;
        longint tr, arg, n0, n1, n2, dg;
        longint q [4];
        longint unsigned root;
        quat_t  o;
        a00 = m[0]; a10 = m[1]; a20 = m[2];
        a01 = m[3]; a11 = m[4]; a21 = m[5];
        a02 = m[6]; a12 = m[7]; a22 = m[8];
        tr  = a00 + a11 + a22;
        q   = '{0, 0, 0, 0};
        o   = '0;
        if (tr > 0)
        begin
            o.branch = rmq_pkg::CASE_TRACE;
            arg = tr + ONE;
            n0 = a21 - a12; n1 = a02 - a20; n2 = a10 - a01;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            o.branch = rmq_pkg::CASE_X;
            arg = ONE + a00 - a11 - a22;
            n0 = a21 - a12; n1 = a01 + a10; n2 = a02 + a20;
        end
        else if (a11 > a22)
        begin
            o.branch = rmq_pkg::CASE_Y;
            arg = ONE + a11 - a00 - a22;
            n0 = a02 - a20; n1 = a01 + a10; n2 = a12 + a21;
        end
        else
        begin
            o.branch = rmq_pkg::CASE_Z;
            arg = ONE + a22 - a00 - a11;
            n0 = a10 - a01; n1 = a02 + a20; n2 = a12 + a21;
        end
        if (arg <= 0)
            o.degen = 1'b1;
        else
        begin
            root = root_floor(longint'(arg) << FB);
            dg   = root >> 1;
            case (o.branch)
                rmq_pkg::CASE_TRACE: q = '{dg, div_round(n0, root), div_round(n1, root),
                                           div_round(n2, root)};
                rmq_pkg::CASE_X:     q = '{div_round(n0, root), dg, div_round(n1, root),
                                           div_round(n2, root)};
                rmq_pkg::CASE_Y:     q = '{div_round(n0, root), div_round(n1, root), dg,
                                           div_round(n2, root)};
                default:             q = '{div_round(n0, root), div_round(n1, root),
                                           div_round(n2, root), dg};
            endcase
        end
        o.qw = clip16(q[0]);
        o.qx = clip16(q[1]);
        o.qy = clip16(q[2]);
        o.qz = clip16(q[3]);
        return o;
    endfunction

    // drive one matrix and wait for its acceptance
    task automatic send_matrix(input logic signed [15:0] m [9], input bit typed,
                               input quat_t res, input bit gaps);
        quat_t p;
        while (gaps && $urandom_range(99) < 14)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        p = predict_quat(m);
        if (typed && p !== res)
        begin
            $display("%0t: table row disagrees with prediction: expected %h actual %h",
                     $time, res, p);
            errors++;
        end
        for (int i = 0; i < 9; i++)
            s_axis_tdata[16*i +: 16] <= m[i];
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        quat_queue.push_back(typed ? res : p);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rnd_elem(input int span);
        case ($urandom_range(9))
            0:       return 16'sh4000;
            1:       return -16'sh4000;
            2:       return 16'($urandom());
            default: return 16'($urandom_range(2 * span) - span);
        endcase
    endfunction

    // random matrix, mostly rotation-like: large diagonal in one branch, small off-diagonal
    function automatic void rand_matrix(output logic signed [15:0] m [9]);
        int b;
        for (int i = 0; i < 9; i++)
            m[i] = 16'($urandom_range(2 * ONE) - ONE);
        if ($urandom_range(9) < 2)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = rnd_elem(ONE);
            return;
        end
        b = $urandom_range(3);
        for (int i = 0; i < 3; i++)
            m[4 * i] = 16'(-int'($urandom_range(ONE)));
        if (b == 0)
            for (int i = 0; i < 3; i++)
                m[4 * i] = 16'($urandom_range(ONE));
        else
            m[4 * (b - 1)] = 16'($urandom_range(ONE));
        for (int i = 0; i < 9; i++)
            if (i % 4 != 0)
                m[i] = 16'($urandom_range(ONE / 2) - ONE / 4);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (200) @(negedge clk);
                sink_hold = 1'b0;
            end
            m_axis_tready <= sink_busy_free || ($urandom_range(99) >= 14);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        quat_t a;
        quat_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.qw = m_axis_tdata[15:0];
            a.qx = m_axis_tdata[31:16];
            a.qy = m_axis_tdata[47:32];
            a.qz = m_axis_tdata[63:48];
            a.branch = m_axis_tuser[1:0];
            a.degen  = m_axis_tuser[2];
            if (quat_queue.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
            end
            else
            begin
                e = quat_queue.pop_front();
                if (a.qw !== e.qw || a.qx !== e.qx || a.qy !== e.qy || a.qz !== e.qz
                    || a.branch !== e.branch || a.degen !== e.degen)
                begin
                    $display("%0t: mismatch expected w %h x %h y %h z %h case %0d deg %b",
                             $time, e.qw, e.qx, e.qy, e.qz, e.branch, e.degen);
                    $display("%0t:          actual   w %h x %h y %h z %h case %0d deg %b",
                             $time, a.qw, a.qx, a.qy, a.qz, a.branch, a.degen);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        row_t rows [$];
        row_t r;
        logic signed [15:0] m [9];
        errors         = 0;
        cycles         = 0;
        sink_hold      = 1'b0;
        sink_busy_free = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity: trace form, w = 1
        r.m = '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000};
        r.typed = 1; r.res = '{16'h0, 16'h0, 16'h0, 16'h4000, rmq_pkg::CASE_TRACE, 1'b0};
        rows.push_back(r);
        // 180 deg about x: x largest, x = 1
        r.m = '{16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, -16'sh4000};
        r.typed = 1; r.res = '{16'h0, 16'h0, 16'h4000, 16'h0, rmq_pkg::CASE_X, 1'b0};
        rows.push_back(r);
        // 180 deg about y
        r.m = '{-16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, -16'sh4000};
        r.typed = 1; r.res = '{16'h0, 16'h4000, 16'h0, 16'h0, rmq_pkg::CASE_Y, 1'b0};
        rows.push_back(r);
        // 180 deg about z
        r.m = '{-16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, 16'sh4000};
        r.typed = 1; r.res = '{16'h4000, 16'h0, 16'h0, 16'h0, rmq_pkg::CASE_Z, 1'b0};
        rows.push_back(r);
        // all zero: z branch, arg = ONE
        r.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        r.typed = 1; r.res = '{16'h2000, 16'h0, 16'h0, 16'h0, rmq_pkg::CASE_Z, 1'b0};
        rows.push_back(r);
        // x branch with a zero diagonal element
        r.m = '{16'sh0, 0, 0, 0, -16'sh4000, 0, 0, 0, -16'sh4000};
        r.typed = 0; rows.push_back(r);
        r.m = '{-16'sh8000, 0, 0, 0, -16'sh8000, 0, 0, 0, 16'sh7fff};
        r.typed = 0; rows.push_back(r);
        // trace just positive with diagonal extremes
        r.m = '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, -16'sh8000};
        r.typed = 0; rows.push_back(r);
        r.m = '{-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff,
                -16'sh8000, 16'sh7fff, -16'sh8000};
        r.typed = 0; rows.push_back(r);
        // field extremes, saturating off-diagonal terms
        r.m = '{16'sh0001, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh0001, 16'sh7fff,
                16'sh7fff, -16'sh8000, -16'sh0001};
        r.typed = 0; rows.push_back(r);
        r.m = '{-16'sh4000, -16'sh4000, -16'sh4000, 16'sh4000, -16'sh4000, 16'sh4000,
                16'sh4000, 16'sh4000, -16'sh4000};
        r.typed = 0; rows.push_back(r);
        r.m = '{16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
                16'shffff, 16'shffff, 16'shffff};
        r.typed = 0; rows.push_back(r);
        // ties on the diagonal
        r.m = '{-16'sh1000, 0, 0, 0, -16'sh1000, 0, 0, 0, -16'sh1000};
        r.typed = 0; rows.push_back(r);
        r.m = '{-16'sh1000, 0, 0, 0, -16'sh1000, 0, 0, 0, -16'sh2000};
        r.typed = 0; rows.push_back(r);
        // 90 deg about z
        r.m = '{0, 16'sh4000, 0, -16'sh4000, 0, 0, 0, 0, 16'sh4000};
        r.typed = 0; rows.push_back(r);

        foreach (rows[i])
            send_matrix(rows[i].m, rows[i].typed, rows[i].res, 1'b0);

        // random part; first stretch with no idling on either side
        sink_busy_free = 1'b1;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 150)
                sink_busy_free = 1'b0;
            if (n == 300)
                sink_hold = 1'b1;
            if (n == 500)
            begin
                s_axis_tvalid <= 1'b0;
                while (quat_queue.size() != 0)
                    @(negedge clk);
            end
            rand_matrix(m);
            send_matrix(m, 1'b0, '0, n >= 150);
        end
        s_axis_tvalid <= 1'b0;

        while (quat_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
